// ===== src/spid_pkg.sv =====
`timescale 1ns / 1ps

package spid_pkg;

    // Command codes of an input beat
    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_WIDTH = 3;
    localparam int unsigned CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_MODE   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE_RANGE = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SOFT_RANGE   = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SOFT_SLOPE   = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRIVE_MAX    = 3'd7;

    // Bits of integ_mode
    localparam int unsigned MODE_RANGE_BIT = 0;
    localparam int unsigned MODE_SOFT_BIT  = 1;

    typedef struct packed {
        logic        command;
        logic [14:0] set_point;
        logic [14:0] process_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         drive;
        logic signed [15:0] prop_term;
        logic signed [15:0] integ_term;
        logic signed [15:0] deriv_term;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] prop;
        logic signed [15:0] integ;
        logic signed [15:0] deriv;
    } t_terms;

endpackage

// ===== src/saturating_pid_controller.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Beat payload
// ---------+-----------+---------------------+----------------------------------------
// input    | in        | i_valid / o_stall   | i_data: command, set_point, process_value
// result   | out       | o_valid / i_stall   | o_data: drive, prop/integ/deriv terms
// config   | in        | i_cfg_we            | i_cfg_index, i_cfg_data (no read-back)
//
// One beat is taken per clock while o_stall is low. A control step passes stages 1-4,
// both dividers and the output register; an init beat updates state, gives no result.
// The sustained rate is set by the integrator loop: one add and clamp per unstalled cycle.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears prev_process and
// the integrator, and loads the register defaults. A stall on the result side
// holds the output register; upstream stages keep filling bubbles until full.
module saturating_pid_controller
    import spid_pkg::*;
#(
    parameter int PROP_LIMIT  = 16000,
    parameter int INTEG_CEIL  = 3000000,
    parameter int INTEG_FLOOR = 0,
    parameter int INTEG_SCALE = 100,
    parameter int DIFF_LIMIT  = 10000,
    parameter int SUM_SCALE   = 100
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  t_in_item                   i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output t_out_item                  o_data,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    // Clamp bounds at the widths of the values they limit
    localparam logic signed [24:0] PROP_HI  = 25'(PROP_LIMIT);
    localparam logic signed [24:0] PROP_LO  = 25'(-PROP_LIMIT);
    localparam logic signed [24:0] DIFF_HI  = 25'(DIFF_LIMIT);
    localparam logic signed [24:0] DIFF_LO  = 25'(-DIFF_LIMIT);
    localparam logic signed [31:0] INTEG_HI = 32'(INTEG_CEIL);
    localparam logic signed [31:0] INTEG_LO = 32'(INTEG_FLOOR);

    localparam int unsigned IDIV_SIDE = 33;   // sign of accumulator, prop, deriv
    localparam int unsigned SDIV_SIDE = $bits(t_terms);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  r_prop_gain;
    logic [7:0]  r_integ_gain;
    logic [7:0]  r_deriv_gain;
    logic [1:0]  r_integ_mode;
    logic [14:0] r_enable_range;
    logic [14:0] r_soft_range;
    logic [15:0] r_soft_slope;
    logic [7:0]  r_drive_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= 8'd8;
            r_integ_gain   <= 8'd100;
            r_deriv_gain   <= 8'd10;
            r_integ_mode   <= 2'd0;
            r_enable_range <= 15'd1000;
            r_soft_range   <= 15'd200;
            r_soft_slope   <= 16'd500;
            r_drive_max    <= 8'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROP_GAIN:    r_prop_gain    <= i_cfg_data[7:0];
                REG_INTEG_GAIN:   r_integ_gain   <= i_cfg_data[7:0];
                REG_DERIV_GAIN:   r_deriv_gain   <= i_cfg_data[7:0];
                REG_INTEG_MODE:   r_integ_mode   <= i_cfg_data[1:0];
                REG_ENABLE_RANGE: r_enable_range <= i_cfg_data[14:0];
                REG_SOFT_RANGE:   r_soft_range   <= i_cfg_data[14:0];
                REG_SOFT_SLOPE:   r_soft_slope   <= i_cfg_data[15:0];
                REG_DRIVE_MAX:    r_drive_max    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers and handshake
    // ------------------------------------------------------------------
    logic                r_s1_valid;
    t_in_item            r_s1;

    logic                r_s2_valid;
    logic                r_s2_init;
    logic signed [15:0]  r_s2_prop;
    logic signed [15:0]  r_s2_deriv;
    logic signed [24:0]  r_s2_kiprod;
    logic signed [31:0]  r_s2_lim;
    logic                r_s2_clear;

    logic                r_s3_valid;
    logic signed [31:0]  r_s3_acc;
    logic signed [15:0]  r_s3_prop;
    logic signed [15:0]  r_s3_deriv;

    logic                r_s4_valid;
    logic signed [17:0]  r_s4_sum;
    t_terms              r_s4_terms;

    logic                r_out_valid;
    t_out_item           r_out;

    logic [14:0]         r_prev;
    logic signed [31:0]  r_integ;

    logic                w_out_ready;
    logic                w_sdiv_in_ready;
    logic                w_s4_ready;
    logic                w_idiv_in_ready;
    logic                w_s3_ready;
    logic                w_s2_go;
    logic                w_s2_ready;
    logic                w_s1_go;
    logic                w_s1_ready;
    logic                w_in_fire;
    logic                w_s3_load;
    logic                w_idiv_valid;
    logic                w_s4_load;
    logic                w_sdiv_valid;
    logic                w_out_load;

    // Ready flows back from the output register; each stage fills its bubble
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_s4_ready  = !r_s4_valid || w_sdiv_in_ready;
    assign w_s3_ready  = !r_s3_valid || w_idiv_in_ready;
    // An init beat leaves stage 2 without a slot downstream: it only clears state
    assign w_s2_go     = r_s2_valid && (r_s2_init || w_s3_ready);
    assign w_s2_ready  = !r_s2_valid || w_s2_go;
    assign w_s1_go     = r_s1_valid && w_s2_ready;
    assign w_s1_ready  = !r_s1_valid || w_s2_ready;
    assign w_in_fire   = i_valid && w_s1_ready;
    assign w_s3_load   = w_s2_go && !r_s2_init;
    assign w_s4_load   = w_idiv_valid && w_s4_ready;
    assign w_out_load  = w_sdiv_valid && w_out_ready;

    assign o_stall = !w_s1_ready;

    // ------------------------------------------------------------------
    // Stage 1 -> 2: error, gain products, clamps, integrator limit
    // ------------------------------------------------------------------
    logic signed [15:0]  w_err;
    logic signed [15:0]  w_diff;
    logic signed [15:0]  w_range_s;
    logic signed [15:0]  w_soft_s;
    logic signed [24:0]  w_prop_prod;
    logic signed [24:0]  w_deriv_prod;
    logic signed [24:0]  w_ki_prod;
    logic signed [15:0]  w_prop;
    logic signed [15:0]  w_deriv;
    logic                w_clear;
    logic [14:0]         w_soft_diff;
    logic [30:0]         w_soft_lim;
    logic signed [31:0]  w_lim;

    assign w_err        = $signed({1'b0, r_s1.set_point}) - $signed({1'b0, r_s1.process_value});
    assign w_diff       = $signed({1'b0, r_prev}) - $signed({1'b0, r_s1.process_value});
    assign w_range_s    = $signed({1'b0, r_enable_range});
    assign w_soft_s     = $signed({1'b0, r_soft_range});

    assign w_prop_prod  = w_err * $signed({1'b0, r_prop_gain});
    assign w_ki_prod    = w_err * $signed({1'b0, r_integ_gain});
    assign w_deriv_prod = w_diff * $signed({1'b0, r_deriv_gain});

    always_comb begin
        if (w_prop_prod > PROP_HI) begin
            w_prop = 16'(PROP_HI);
        end else if (w_prop_prod < PROP_LO) begin
            w_prop = 16'(PROP_LO);
        end else begin
            w_prop = 16'(w_prop_prod);
        end

        if (w_deriv_prod > DIFF_HI) begin
            w_deriv = 16'(DIFF_HI);
        end else if (w_deriv_prod < DIFF_LO) begin
            w_deriv = 16'(DIFF_LO);
        end else begin
            w_deriv = 16'(w_deriv_prod);
        end
    end

    // In range mode, drop the integrator when the error leaves the enable window
    assign w_clear = r_integ_mode[MODE_RANGE_BIT] &&
                     (w_err > w_range_s || w_err < -w_range_s);

    // Soft limit shrinks linearly toward zero as the error nears soft_range
    assign w_soft_diff = r_soft_range - w_err[14:0];
    assign w_soft_lim  = w_soft_diff * r_soft_slope;

    always_comb begin
        if (!r_integ_mode[MODE_SOFT_BIT]) begin
            w_lim = INTEG_HI;
        end else if (w_err > w_soft_s) begin
            w_lim = '0;
        end else if (w_err < 0) begin
            w_lim = INTEG_HI;
        end else begin
            w_lim = 32'(w_soft_lim);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> 3: integrator accumulate and clamp (the feedback loop)
    // ------------------------------------------------------------------
    logic signed [32:0]  w_acc_sum;
    logic signed [31:0]  n_integ;

    assign w_acc_sum = r_s2_clear ? 33'sd0 : 33'(r_integ) + 33'(r_s2_kiprod);

    always_comb begin
        if (w_acc_sum > 33'(r_s2_lim)) begin
            n_integ = r_s2_lim;
        end else if (w_acc_sum < 33'(INTEG_LO)) begin
            n_integ = INTEG_LO;
        end else begin
            n_integ = 32'(w_acc_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_integ     <= '0;
        end else begin
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_go) begin
                r_s2_valid <= 1'b1;
                r_prev     <= r_s1.process_value;
            end else if (w_s2_go) begin
                r_s2_valid <= 1'b0;
            end

            if (w_s2_go) begin
                r_integ <= r_s2_init ? 32'sd0 : n_integ;
            end

            if (w_s3_load) begin
                r_s3_valid <= 1'b1;
            end else if (w_idiv_in_ready) begin
                r_s3_valid <= 1'b0;
            end

            if (w_s4_load) begin
                r_s4_valid <= 1'b1;
            end else if (w_sdiv_in_ready) begin
                r_s4_valid <= 1'b0;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Integrator / INTEG_SCALE, truncated toward zero on the magnitude
    // ------------------------------------------------------------------
    logic                  w_acc_neg;
    logic [30:0]           w_acc_mag;
    logic [14:0]           w_idiv_q;
    logic                  w_idiv_sat;
    logic [IDIV_SIDE-1:0]  w_idiv_side;
    logic                  w_i_neg;
    logic signed [15:0]    w_i_prop;
    logic signed [15:0]    w_i_deriv;
    logic signed [15:0]    w_integ_term;
    logic signed [17:0]    w_sum;

    assign w_acc_neg = r_s3_acc[31];
    assign w_acc_mag = w_acc_neg ? 31'(-r_s3_acc) : 31'(r_s3_acc);

    spid_cdiv #(
        .DIVISOR    (INTEG_SCALE),
        .X_WIDTH    (31),
        .Q_WIDTH    (15),
        .SIDE_WIDTH (IDIV_SIDE)
    ) u_integ_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .o_ready (w_idiv_in_ready),
        .i_x     (w_acc_mag),
        .i_side  ({w_acc_neg, r_s3_prop, r_s3_deriv}),
        .o_valid (w_idiv_valid),
        .i_ready (w_s4_ready),
        .o_q     (w_idiv_q),
        .o_sat   (w_idiv_sat),
        .o_side  (w_idiv_side)
    );

    assign w_i_neg   = w_idiv_side[32];
    assign w_i_prop  = w_idiv_side[31:16];
    assign w_i_deriv = w_idiv_side[15:0];

    // Saturate to the int16 range instead of wrapping
    always_comb begin
        if (w_i_neg) begin
            w_integ_term = w_idiv_sat ? -16'sd32768 : -$signed({1'b0, w_idiv_q});
        end else begin
            w_integ_term = w_idiv_sat ? 16'sd32767 : $signed({1'b0, w_idiv_q});
        end
    end

    assign w_sum = 18'(w_i_prop) + 18'(w_integ_term) + 18'(w_i_deriv);

    // ------------------------------------------------------------------
    // Sum / SUM_SCALE, clamped to 0..drive_max
    // ------------------------------------------------------------------
    logic [16:0]           w_sum_mag;
    logic [7:0]            w_sdiv_q;
    logic                  w_sdiv_sat;
    logic [SDIV_SIDE-1:0]  w_sdiv_side;
    t_terms                w_out_terms;
    logic [7:0]            w_drive_q;
    t_out_item             n_out;

    // A negative sum truncates to a quotient of zero or below: force zero
    assign w_sum_mag = r_s4_sum[17] ? 17'd0 : r_s4_sum[16:0];

    spid_cdiv #(
        .DIVISOR    (SUM_SCALE),
        .X_WIDTH    (17),
        .Q_WIDTH    (8),
        .SIDE_WIDTH (SDIV_SIDE)
    ) u_sum_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_valid),
        .o_ready (w_sdiv_in_ready),
        .i_x     (w_sum_mag),
        .i_side  (r_s4_terms),
        .o_valid (w_sdiv_valid),
        .i_ready (w_out_ready),
        .o_q     (w_sdiv_q),
        .o_sat   (w_sdiv_sat),
        .o_side  (w_sdiv_side)
    );

    assign w_out_terms = t_terms'(w_sdiv_side);
    assign w_drive_q   = w_sdiv_sat ? 8'hFF : w_sdiv_q;

    always_comb begin
        n_out.drive      = (w_drive_q > r_drive_max) ? r_drive_max : w_drive_q;
        n_out.prop_term  = w_out_terms.prop;
        n_out.integ_term = w_out_terms.integ;
        n_out.deriv_term = w_out_terms.deriv;
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1 <= i_data;
        end
        if (w_s1_go) begin
            r_s2_init   <= (r_s1.command == CMD_INIT);
            r_s2_prop   <= w_prop;
            r_s2_deriv  <= w_deriv;
            r_s2_kiprod <= w_ki_prod;
            r_s2_lim    <= w_lim;
            r_s2_clear  <= w_clear;
        end
        if (w_s3_load) begin
            r_s3_acc   <= n_integ;
            r_s3_prop  <= r_s2_prop;
            r_s3_deriv <= r_s2_deriv;
        end
        if (w_s4_load) begin
            r_s4_sum         <= w_sum;
            r_s4_terms.prop  <= w_i_prop;
            r_s4_terms.integ <= w_integ_term;
            r_s4_terms.deriv <= w_i_deriv;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== src/spid_cdiv.sv =====
`timescale 1ns / 1ps

// Two-stage unsigned divide by a constant with saturation.
// Stage A: range check and reciprocal multiply (quotient estimate, low by at most one).
// Stage B: back-multiply, compare remainder, correct.
module spid_cdiv
    import spid_pkg::*;
#(
    parameter int unsigned DIVISOR    = 100,
    parameter int unsigned X_WIDTH    = 31,
    parameter int unsigned Q_WIDTH    = 15,
    parameter int unsigned SIDE_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [X_WIDTH-1:0]    i_x,
    input  logic [SIDE_WIDTH-1:0] i_side,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [Q_WIDTH-1:0]    o_q,
    output logic                  o_sat,
    output logic [SIDE_WIDTH-1:0] o_side
);

    localparam int unsigned      DIV_BITS  = $clog2(DIVISOR);
    localparam int unsigned      SHIFT     = Q_WIDTH + DIV_BITS;
    localparam int unsigned      MUL_WIDTH = Q_WIDTH + 1;
    localparam int unsigned      DIV_WIDTH = $clog2(DIVISOR + 1);
    localparam longint unsigned  RECIP     = (64'd1 << SHIFT) / DIVISOR;
    localparam longint unsigned  SAT_LIMIT = (64'd1 << Q_WIDTH) * DIVISOR;

    logic                           r_va;
    logic                           r_vb;
    logic [SHIFT-1:0]               r_x_a;
    logic [Q_WIDTH-1:0]             r_q0;
    logic                           r_sat_a;
    logic [SIDE_WIDTH-1:0]          r_side_a;
    logic [Q_WIDTH-1:0]             r_q;
    logic                           r_sat;
    logic [SIDE_WIDTH-1:0]          r_side;

    logic                           w_ready_a;
    logic                           w_ready_b;
    logic                           w_load_a;
    logic                           w_load_b;
    logic                           w_sat;
    logic [SHIFT-1:0]               w_x_s;
    logic [SHIFT+MUL_WIDTH-1:0]     w_prod;
    logic [Q_WIDTH+DIV_WIDTH-1:0]   w_qd;
    logic [SHIFT-1:0]               w_rem;
    logic [Q_WIDTH-1:0]             n_q;

    assign w_ready_b = !r_vb || i_ready;
    assign w_ready_a = !r_va || w_ready_b;
    assign w_load_a  = i_valid && w_ready_a;
    assign w_load_b  = r_va && w_ready_b;
    assign o_ready   = w_ready_a;

    assign w_sat  = 64'(i_x) >= SAT_LIMIT;
    assign w_x_s  = SHIFT'(i_x);
    assign w_prod = w_x_s * MUL_WIDTH'(RECIP);

    assign w_qd  = r_q0 * DIV_WIDTH'(DIVISOR);
    assign w_rem = r_x_a - SHIFT'(w_qd);
    assign n_q   = (w_rem >= SHIFT'(DIVISOR)) ? r_q0 + 1'b1 : r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_load_a) begin
                r_va <= 1'b1;
            end else if (w_load_b) begin
                r_va <= 1'b0;
            end
            if (w_load_b) begin
                r_vb <= 1'b1;
            end else if (i_ready) begin
                r_vb <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_a) begin
            r_x_a    <= w_x_s;
            r_q0     <= w_prod[SHIFT+Q_WIDTH-1:SHIFT];
            r_sat_a  <= w_sat;
            r_side_a <= i_side;
        end
        if (w_load_b) begin
            r_q    <= n_q;
            r_sat  <= r_sat_a;
            r_side <= r_side_a;
        end
    end

    assign o_valid = r_vb;
    assign o_q     = r_q;
    assign o_sat   = r_sat;
    assign o_side  = r_side;

endmodule
